FILE: src/mcsvm_pkg.sv
// Shared types, widths and helpers for the multiclass SVM reduced-problem solver.
// Used by the divider and the solver; no dependencies of its own.
package mcsvm_pkg;

  localparam int MAX_CLASSES = 32;
  localparam int CW = $clog2(MAX_CLASSES);   // class index bits
  localparam int NW = CW + 1;                // count bits
  localparam int VW = 32;                    // score and alpha width
  localparam int SVW = VW + 1;               // sort value width (q + 1.0)
  localparam int DVW = 48;                   // divider dividend width
  localparam int DSW = 31;                   // divider divisor width
  localparam int QSW = 40;                   // quotient sum width
  localparam int PW = 40;                    // potential width
  localparam int ONE_Q = 65536;

  typedef struct packed {
    logic signed [VW-1:0] score;
    logic [CW-1:0]        true_label;
    logic [DSW-1:0]       scale;
  } in_item_t;

  typedef struct packed {
    logic [CW-1:0]        class_index;
    logic signed [VW-1:0] alpha;
    logic [NW-1:0]        active_count;
    logic                 last;
  } out_item_t;

  // one entry of the reduced list: value and the class it belongs to
  typedef struct packed {
    logic signed [SVW-1:0] value;
    logic [CW-1:0]         cls;
  } entry_t;

  // saturate a wide signed value to the alpha width
  function automatic logic signed [VW-1:0] sat_q(input logic signed [DVW-1:0] v);
    logic [DVW-VW:0] top;
    top = v[DVW-1:VW-1];
    if ((top == '0) || (top == '1)) begin
      return v[VW-1:0];
    end
    return v[DVW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
  endfunction

  // descending by value, ties by ascending class
  function automatic logic goes_before(input entry_t x, input entry_t y);
    if (x.value != y.value) begin
      return $signed(x.value) > $signed(y.value);
    end
    return x.cls < y.cls;
  endfunction

endpackage

FILE: src/mcsvm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mcsvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/mcsvm_div.sv
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// Depends on mcsvm_pkg for widths.
module mcsvm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mcsvm_pkg::DVW-1:0]    dividend,
  input  logic [mcsvm_pkg::DSW-1:0]    divisor,
  output logic                         done,
  output logic [mcsvm_pkg::DVW-1:0]    quotient
);
  import mcsvm_pkg::*;

  logic           busy;
  logic [5:0]     count;
  logic           neg;
  logic [DVW-1:0] q;
  logic [DSW-1:0] rem;
  logic [DSW-1:0] dvs;
  logic [DSW+1:0] diff;
  logic           fits;

  // trial subtract of the shifted remainder
  assign diff = {1'b0, rem, q[DVW-1]} - {2'b00, dvs};
  assign fits = ~diff[DSW+1];
  assign quotient = neg ? -q : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        neg   <= dividend[DVW-1];
        q     <= dividend[DVW-1] ? -dividend : dividend;
        rem   <= '0;
        dvs   <= divisor;
      end else if (busy) begin
        rem   <= fits ? diff[DSW-1:0] : {rem[DSW-2:0], q[DVW-1]};
        q     <= {q[DVW-2:0], fits};
        count <= count + 6'd1;
        if (count == 6'(DVW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/multiclass_svm_reduced_solver.sv
// Multiclass SVM reduced-problem solver: takes k score items per problem (num_classes
// clamped to 2..MAX_CLASSES), then solves and emits one alpha item per class in index
// order. A problem goes through loading, alpha clearing, a mistake scan with divisions in
// the serial divider (one for the true label, one per mistake, one for the mean or
// threshold), a rank sort of the n-entry reduced list, the potential walk, the alpha pass
// and the emit, which waits on result stalls; the divider and the sort dominate.
// Depends on mcsvm_pkg, mcsvm_ram and mcsvm_div.
module multiclass_svm_reduced_solver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mcsvm_pkg::in_item_t           in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mcsvm_pkg::out_item_t          out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mcsvm_pkg::NW-1:0]      cfg_data
);
  import mcsvm_pkg::*;

  localparam logic [4:0] S_LOAD = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_RDY  = 5'd2;
  localparam logic [4:0] S_GETY = 5'd3;
  localparam logic [4:0] S_QY   = 5'd4;
  localparam logic [4:0] S_SRD  = 5'd5;
  localparam logic [4:0] S_SCHK = 5'd6;
  localparam logic [4:0] S_SDIV = 5'd7;
  localparam logic [4:0] S_CASE = 5'd8;
  localparam logic [4:0] S_TWO0 = 5'd9;
  localparam logic [4:0] S_TWO1 = 5'd10;
  localparam logic [4:0] S_TWO2 = 5'd11;
  localparam logic [4:0] S_RKI  = 5'd12;
  localparam logic [4:0] S_RKL  = 5'd13;
  localparam logic [4:0] S_RK   = 5'd14;
  localparam logic [4:0] S_RKE  = 5'd15;
  localparam logic [4:0] S_WK0  = 5'd16;
  localparam logic [4:0] S_WK1  = 5'd17;
  localparam logic [4:0] S_WKT  = 5'd18;
  localparam logic [4:0] S_WKM  = 5'd19;
  localparam logic [4:0] S_WKS  = 5'd20;
  localparam logic [4:0] S_WKD  = 5'd21;
  localparam logic [4:0] S_APR  = 5'd22;
  localparam logic [4:0] S_APW  = 5'd23;
  localparam logic [4:0] S_ERD  = 5'd24;
  localparam logic [4:0] S_EWR  = 5'd25;

  logic [4:0]             state;
  logic [NW-1:0]          num_classes;
  logic [NW-1:0]          k;
  logic [NW-1:0]          load_count;
  logic [NW-1:0]          idx;
  logic [NW-1:0]          n;
  logic [NW-1:0]          j;
  logic [NW-1:0]          lim;
  logic [NW-1:0]          act;
  logic [CW-1:0]          y;
  logic [DSW-1:0]         a;
  logic signed [VW-1:0]   sy;
  logic signed [VW-1:0]   qy;
  logic signed [QSW-1:0]  quotient_sum;
  entry_t                 vi;
  logic [CW-1:0]          rank;
  logic                   cmpv;
  logic signed [SVW-1:0]  prev;
  logic signed [SVW-1:0]  pp;
  logic signed [SVW-1:0]  cur;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   phi0;
  logic signed [PW-1:0]   phi1;
  logic                   mean_path;
  logic signed [DVW-1:0]  base;
  logic signed [VW-1:0]   t_pos;

  logic                   in_acc;
  logic                   out_free;

  // memory ports
  logic                   sc_we;
  logic [CW-1:0]          sc_raddr;
  logic [VW-1:0]          sc_rd;
  logic                   ls_we;
  logic [CW-1:0]          ls_waddr;
  entry_t                 ls_wdata;
  logic [CW-1:0]          ls_raddr;
  entry_t                 ls_rd;
  logic                   so_we;
  logic [CW-1:0]          so_raddr;
  entry_t                 so_rd;
  logic [CW-1:0]          rank_fin;
  logic                   al_we;
  logic [CW-1:0]          al_waddr;
  logic [VW-1:0]          al_wdata;
  logic [VW-1:0]          al_rd;

  // divider
  logic                   div_start;
  logic [DVW-1:0]         div_dvd;
  logic [DSW-1:0]         div_dvs;
  logic                   div_done;
  logic [DVW-1:0]         div_q;
  logic signed [VW-1:0]   q_sat;

  // two-class and alpha pass arithmetic
  logic signed [SVW:0]    diff2;
  logic signed [SVW:0]    half2;
  logic signed [SVW:0]    tmin;
  logic signed [DVW-1:0]  ap_val;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_LOAD);
  assign in_acc    = in_valid & in_ready;
  assign out_free  = ~out_valid | out_ready;

  // clamp the class count into its legal range
  always_comb begin
    if (num_classes < NW'(2)) begin
      k = NW'(2);
    end else if (num_classes > NW'(MAX_CLASSES)) begin
      k = NW'(MAX_CLASSES);
    end else begin
      k = num_classes;
    end
  end

  assign q_sat = sat_q($signed(div_q));

  // closed two-class form
  assign diff2 = $signed({ls_rd.value[SVW-1], ls_rd.value}) -
                 $signed({{2{qy[VW-1]}}, qy});
  assign half2 = $signed(diff2 + (SVW + 1)'(diff2[SVW])) >>> 1;
  assign tmin  = (half2 > $signed((SVW + 1)'(ONE_Q))) ? $signed((SVW + 1)'(ONE_Q)) : half2;

  // alpha of one sorted entry
  always_comb begin
    ap_val = '0;
    if (idx < lim) begin
      ap_val = base - $signed({{(DVW-SVW){so_rd.value[SVW-1]}}, so_rd.value});
    end
    if (so_rd.cls == y) begin
      ap_val = ap_val + $signed(DVW'(ONE_Q));
    end
  end

  assign rank_fin = rank + CW'(cmpv & goes_before(ls_rd, vi));

  // memory address and write control
  always_comb begin
    sc_we    = in_acc;
    sc_raddr = (state == S_RDY) ? y : idx[CW-1:0];
    ls_we    = 1'b0;
    ls_waddr = n[CW-1:0];
    ls_wdata = {$signed({q_sat[VW-1], q_sat}), idx[CW-1:0]};
    ls_raddr = '0;
    so_we    = (state == S_RKE);
    so_raddr = idx[CW-1:0];
    al_we    = 1'b0;
    al_waddr = idx[CW-1:0];
    al_wdata = '0;
    unique case (state)
      S_CLR: begin
        al_we = 1'b1;
      end
      S_SDIV: begin
        ls_we = div_done;
      end
      S_CASE: begin
        ls_we    = (n > NW'(1));
        ls_wdata = {$signed({qy[VW-1], qy}) + $signed(SVW'(ONE_Q)), y};
      end
      S_RKI: begin
        ls_raddr = idx[CW-1:0];
      end
      S_RK: begin
        ls_raddr = j[CW-1:0];
      end
      S_TWO1: begin
        al_we    = 1'b1;
        al_waddr = ls_rd.cls;
        al_wdata = sat_q(-$signed({{(DVW-SVW-1){tmin[SVW]}}, tmin}));
      end
      S_TWO2: begin
        al_we    = 1'b1;
        al_waddr = y;
        al_wdata = t_pos;
      end
      S_WK0: begin
        so_raddr = '0;
      end
      S_APW: begin
        al_we    = 1'b1;
        al_waddr = so_rd.cls;
        al_wdata = sat_q(ap_val);
      end
      default: begin
      end
    endcase
  end

  // divider launch
  always_comb begin
    div_start = 1'b0;
    div_dvd   = {sc_rd, 16'h0000};
    div_dvs   = a;
    unique case (state)
      S_GETY: begin
        div_start = 1'b1;
      end
      S_SCHK: begin
        div_start = ($signed(sc_rd) > sy);
      end
      S_WKT: begin
        div_start = ~((phi1 > 0) && (idx < n));
        if (phi1 > 0) begin
          div_dvd = {{(DVW-QSW){quotient_sum[QSW-1]}}, quotient_sum};
          div_dvs = DSW'(n);
        end else begin
          div_dvd = {{(DVW-PW){phi0[PW-1]}}, phi0};
          div_dvs = DSW'(idx - NW'(1));
        end
      end
      default: begin
      end
    endcase
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      num_classes <= NW'(MAX_CLASSES);
      load_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid & cfg_ready) begin
        num_classes <= cfg_data;
      end
      // the emit state sets valid itself whenever the output is free
      if (out_valid & out_ready & (state != S_EWR)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            y <= in_item.true_label;
            a <= (in_item.scale == '0) ? DSW'(1) : in_item.scale;
            if (load_count + NW'(1) >= k) begin
              load_count <= '0;
              idx        <= '0;
              state      <= S_CLR;
            end else begin
              load_count <= load_count + NW'(1);
            end
          end
        end
        S_CLR: begin
          if (idx == k - NW'(1)) begin
            idx <= '0;
            if ({1'b0, y} >= k) begin
              act   <= '0;
              state <= S_ERD;
            end else begin
              state <= S_RDY;
            end
          end else begin
            idx <= idx + NW'(1);
          end
        end
        S_RDY: begin
          state <= S_GETY;
        end
        S_GETY: begin
          sy    <= sc_rd;
          state <= S_QY;
        end
        S_QY: begin
          if (div_done) begin
            qy           <= q_sat;
            idx          <= '0;
            n            <= '0;
            quotient_sum <= '0;
            state        <= S_SRD;
          end
        end
        S_SRD: begin
          state <= S_SCHK;
        end
        S_SCHK, S_SDIV: begin
          if (state == S_SCHK && ($signed(sc_rd) > sy)) begin
            state <= S_SDIV;
          end else if (state == S_SCHK || div_done) begin
            if (state == S_SDIV) begin
              quotient_sum <= quotient_sum + QSW'(q_sat);
              n            <= n + NW'(1);
            end
            if (idx == k - NW'(1)) begin
              state <= S_CASE;
            end else begin
              idx   <= idx + NW'(1);
              state <= S_SRD;
            end
          end
        end
        S_CASE: begin
          idx <= '0;
          if (n == '0) begin
            act   <= '0;
            state <= S_ERD;
          end else if (n == NW'(1)) begin
            state <= S_TWO0;
          end else begin
            quotient_sum <= quotient_sum + QSW'(qy);
            n            <= n + NW'(1);
            act          <= n + NW'(1);
            state        <= S_RKI;
          end
        end
        S_TWO0: begin
          state <= S_TWO1;
        end
        S_TWO1: begin
          t_pos <= sat_q($signed({{(DVW-SVW-1){tmin[SVW]}}, tmin}));
          act   <= NW'(2);
          state <= S_TWO2;
        end
        S_TWO2: begin
          idx   <= '0;
          state <= S_ERD;
        end
        S_RKI: begin
          state <= S_RKL;
        end
        S_RKL: begin
          vi    <= ls_rd;
          j     <= '0;
          rank  <= '0;
          cmpv  <= 1'b0;
          state <= S_RK;
        end
        S_RK: begin
          cmpv <= 1'b1;
          rank <= rank_fin;
          if (j == n - NW'(1)) begin
            state <= S_RKE;
          end else begin
            j <= j + NW'(1);
          end
        end
        S_RKE: begin
          if (idx == n - NW'(1)) begin
            state <= S_WK0;
          end else begin
            idx   <= idx + NW'(1);
            state <= S_RKI;
          end
        end
        S_WK0: begin
          state <= S_WK1;
        end
        S_WK1: begin
          prev  <= so_rd.value;
          idx   <= NW'(1);
          phi0  <= '0;
          phi1  <= PW'(ONE_Q);
          state <= S_WKT;
        end
        S_WKT: begin
          if ((phi1 > 0) && (idx < n)) begin
            state <= S_WKM;
          end else begin
            mean_path <= (phi1 > 0);
            lim       <= (phi1 > 0) ? n : idx - NW'(1);
            state     <= S_WKD;
          end
        end
        S_WKM: begin
          cur   <= so_rd.value;
          prod  <= $signed({1'b0, idx}) *
                   $signed({{(PW-SVW){prev[SVW-1]}}, prev} -
                           {{(PW-SVW){so_rd.value[SVW-1]}}, so_rd.value});
          state <= S_WKS;
        end
        S_WKS: begin
          phi0  <= phi1;
          phi1  <= phi1 - prod;
          pp    <= prev;
          prev  <= cur;
          idx   <= idx + NW'(1);
          state <= S_WKT;
        end
        S_WKD: begin
          if (div_done) begin
            base  <= mean_path ? $signed(div_q) :
                     $signed({{(DVW-SVW){pp[SVW-1]}}, pp}) - $signed(div_q);
            idx   <= '0;
            state <= S_APR;
          end
        end
        S_APR: begin
          state <= S_APW;
        end
        S_APW: begin
          if (idx == n - NW'(1)) begin
            idx   <= '0;
            state <= S_ERD;
          end else begin
            idx   <= idx + NW'(1);
            state <= S_APR;
          end
        end
        S_ERD: begin
          state <= S_EWR;
        end
        S_EWR: begin
          if (out_free) begin
            out_valid             <= 1'b1;
            out_item.class_index  <= idx[CW-1:0];
            out_item.alpha        <= al_rd;
            out_item.active_count <= act;
            out_item.last         <= (idx == k - NW'(1));
            if (idx == k - NW'(1)) begin
              state <= S_LOAD;
            end else begin
              idx   <= idx + NW'(1);
              state <= S_ERD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // raw scores of the current problem
  mcsvm_ram #(.WIDTH(VW), .DEPTH(MAX_CLASSES)) u_score_ram (
    .clk   (clk),
    .we    (sc_we),
    .waddr (load_count[CW-1:0]),
    .wdata (in_item.score),
    .raddr (sc_raddr),
    .rdata (sc_rd)
  );

  // reduced list before sorting
  mcsvm_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_CLASSES)) u_list_ram (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr),
    .wdata (ls_wdata),
    .raddr (ls_raddr),
    .rdata (ls_rd)
  );

  // reduced list in descending order
  mcsvm_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_CLASSES)) u_sort_ram (
    .clk   (clk),
    .we    (so_we),
    .waddr (rank_fin),
    .wdata (vi),
    .raddr (so_raddr),
    .rdata (so_rd)
  );

  // solved alphas by class
  mcsvm_ram #(.WIDTH(VW), .DEPTH(MAX_CLASSES)) u_alpha_ram (
    .clk   (clk),
    .we    (al_we),
    .waddr (al_waddr),
    .wdata (al_wdata),
    .raddr (idx[CW-1:0]),
    .rdata (al_rd)
  );

  mcsvm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule
